/* rtl/emt_pkg.sv */
// Shared types and constants for the extent map table.
// Used by every file of the block; depends on nothing.
`default_nettype none
package emt_pkg;
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int BLK_W = 32;
   localparam int LEN_W = 16;
   localparam logic [LEN_W-1:0] MAX_MERGE_RESET = 16'd32768;

   typedef enum logic [1:0] {
      ACT_APPEND, ACT_REMOVE, ACT_FIND, ACT_NORMALIZE
   } action_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_BAD_INDEX = 2'd1, ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic             unwritten;
      logic [LEN_W-1:0] len;
      logic [BLK_W-1:0] pstart;
      logic [BLK_W-1:0] lstart;
   } entry_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_START, OP_APPEND, OP_CHECK_IDX, OP_FIND_MISS, OP_FIND_CMP,
      OP_READ_I, OP_READ_J, OP_READ_I1, OP_READ_M1, OP_LOAD_CUR, OP_WRITE_CUR,
      OP_SORT_CMP, OP_I_ZERO, OP_SET_M_I, OP_INC_I, OP_MERGE, OP_DEL_WR,
      OP_DEL_END
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic i_end;
      logic j_end;
      logic m_end;
      logic bad_idx;
      logic find_stop;
      logic zero_len;
      logic has_next;
      logic mergeable;
   } dp_status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_APPEND, S_REMOVE, S_FIND, S_FIND_CMP, S_SORT_I, S_SORT_LOAD,
      S_SORT_J, S_SORT_CMP, S_MERGE, S_MERGE_LOAD, S_MERGE_CHK, S_MERGE_CMP,
      S_DEL, S_DEL_WR, S_DONE
   } ctrl_state_type;
endpackage
`default_nettype wire

/* rtl/emt_ifs.sv */
// Channel interfaces for the extent map table: request, response, register write.
// Depends on emt_pkg for field widths.
`default_nettype none
interface emt_req_if;
   import emt_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic [BLK_W-1:0]    logical_block;
   logic [BLK_W-1:0]    physical_start;
   logic [LEN_W-1:0]    extent_length;
   logic                unwritten_flag;
   logic [IDX_W-1:0]    entry_index;
   modport source (output valid, action, logical_block, physical_start, extent_length,
                   unwritten_flag, entry_index, input ready);
   modport sink (input valid, action, logical_block, physical_start, extent_length,
                 unwritten_flag, entry_index, output ready);
endinterface

interface emt_rsp_if;
   import emt_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic             hit;
   logic [IDX_W-1:0] match_index;
   logic [CNT_W-1:0] insert_position;
   logic [CNT_W-1:0] entry_count;
   modport source (output valid, status, hit, match_index, insert_position, entry_count,
                   input ready);
   modport sink (input valid, status, hit, match_index, insert_position, entry_count,
                 output ready);
endinterface

interface emt_csr_if;
   import emt_pkg::*;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/emt_datapath.sv */
// Datapath of the extent map table: entry memory, scan counters, result registers.
// Depends on emt_pkg; driven by emt_ctrl through a command struct.
`default_nettype none
module emt_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire emt_pkg::dp_cmd_type    cmd,
   output emt_pkg::dp_status_type      stat,
   input  wire logic [emt_pkg::BLK_W-1:0] req_lblk,
   input  wire logic [emt_pkg::BLK_W-1:0] req_pstart,
   input  wire logic [emt_pkg::LEN_W-1:0] req_len,
   input  wire logic                   req_flag,
   input  wire logic [emt_pkg::IDX_W-1:0] req_index,
   input  wire logic                   csr_we,
   input  wire logic [emt_pkg::LEN_W-1:0] csr_data,
   output logic [1:0]                  res_status,
   output logic                        res_hit,
   output logic [emt_pkg::IDX_W-1:0]   res_match,
   output logic [emt_pkg::CNT_W-1:0]   res_insert,
   output logic [emt_pkg::CNT_W-1:0]   res_count
);
   import emt_pkg::*;

   entry_type        mem [TABLE_DEPTH];
   entry_type        rdata_ff, cur_ff, new_ff;
   logic [CNT_W-1:0] count_ff, i_ff, j_ff, m_ff;
   logic [BLK_W-1:0] lblk_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [LEN_W-1:0] max_ff;
   status_type       status_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] match_ff;
   logic [CNT_W-1:0] ins_ff;

   logic [CNT_W-1:0] rd_addr;
   logic             wr_en;
   logic [CNT_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [BLK_W:0]   cover_end, l_end, p_end;
   logic [LEN_W:0]   len_sum;
   logic             below, swap, full;

   always_comb begin
      cover_end = {1'b0, rdata_ff.lstart} + (BLK_W+1)'(rdata_ff.len);
      l_end     = {1'b0, cur_ff.lstart} + (BLK_W+1)'(cur_ff.len);
      p_end     = {1'b0, cur_ff.pstart} + (BLK_W+1)'(cur_ff.len);
      len_sum   = (LEN_W+1)'(cur_ff.len) + (LEN_W+1)'(rdata_ff.len);
      below     = lblk_ff < rdata_ff.lstart;
      swap      = cur_ff.lstart > rdata_ff.lstart;
      full      = count_ff >= CNT_W'(TABLE_DEPTH);
      stat.i_end     = i_ff >= count_ff;
      stat.j_end     = j_ff >= count_ff;
      stat.m_end     = (m_ff + CNT_W'(1)) >= count_ff;
      stat.bad_idx   = {1'b0, idx_ff} >= count_ff;
      stat.find_stop = below || ({1'b0, lblk_ff} < cover_end);
      stat.zero_len  = cur_ff.len == '0;
      stat.has_next  = (i_ff + CNT_W'(1)) < count_ff;
      stat.mergeable = (cur_ff.unwritten == rdata_ff.unwritten) &&
                       (l_end == {1'b0, rdata_ff.lstart}) &&
                       (p_end == {1'b0, rdata_ff.pstart}) &&
                       (len_sum <= {1'b0, max_ff});
   end

   always_comb begin
      rd_addr = i_ff;
      wr_en   = 1'b0;
      wr_addr = i_ff;
      wr_data = cur_ff;
      unique case (cmd.op)
         OP_READ_J:  rd_addr = j_ff;
         OP_READ_I1: rd_addr = i_ff + CNT_W'(1);
         OP_READ_M1: rd_addr = m_ff + CNT_W'(1);
         OP_APPEND: begin
            wr_en   = !full;
            wr_addr = count_ff;
            wr_data = new_ff;
         end
         OP_DEL_WR: begin
            wr_en   = 1'b1;
            wr_addr = m_ff;
            wr_data = rdata_ff;
         end
         OP_WRITE_CUR: wr_en = 1'b1;
         OP_SORT_CMP: begin
            wr_en   = swap;
            wr_addr = j_ff;
         end
         OP_MERGE: begin
            wr_en       = 1'b1;
            wr_data.len = len_sum[LEN_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[IDX_W-1:0]] <= wr_data;
      end
      rdata_ff <= mem[rd_addr[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         max_ff    <= MAX_MERGE_RESET;
         status_ff <= ST_OK;
         hit_ff    <= 1'b0;
         match_ff  <= '0;
         ins_ff    <= '0;
      end else begin
         if (csr_we) begin
            max_ff <= csr_data;
         end
         unique case (cmd.op)
            OP_START: begin
               lblk_ff   <= req_lblk;
               new_ff    <= '{unwritten: req_flag, len: req_len, pstart: req_pstart,
                              lstart: req_lblk};
               idx_ff    <= req_index;
               m_ff      <= CNT_W'(req_index);
               i_ff      <= '0;
               status_ff <= ST_OK;
               hit_ff    <= 1'b0;
               match_ff  <= '0;
               ins_ff    <= '0;
            end
            OP_APPEND: begin
               if (full) begin
                  status_ff <= ST_FULL;
               end else begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            OP_CHECK_IDX: begin
               if (stat.bad_idx) begin
                  status_ff <= ST_BAD_INDEX;
               end
            end
            OP_FIND_MISS: ins_ff <= count_ff;
            OP_FIND_CMP: begin
               if (stat.find_stop) begin
                  ins_ff <= i_ff;
                  if (!below) begin
                     hit_ff   <= 1'b1;
                     match_ff <= i_ff[IDX_W-1:0];
                  end
               end else begin
                  i_ff <= i_ff + CNT_W'(1);
               end
            end
            OP_READ_I:    j_ff <= i_ff + CNT_W'(1);
            OP_LOAD_CUR:  cur_ff <= rdata_ff;
            OP_WRITE_CUR: i_ff <= i_ff + CNT_W'(1);
            OP_SORT_CMP: begin
               if (swap) begin
                  cur_ff <= rdata_ff;
               end
               j_ff <= j_ff + CNT_W'(1);
            end
            OP_I_ZERO:  i_ff <= '0;
            OP_SET_M_I: m_ff <= i_ff;
            OP_INC_I:   i_ff <= i_ff + CNT_W'(1);
            OP_MERGE:   m_ff <= i_ff + CNT_W'(1);
            OP_DEL_WR:  m_ff <= m_ff + CNT_W'(1);
            OP_DEL_END: count_ff <= count_ff - CNT_W'(1);
            default: ;
         endcase
      end
   end

   assign res_status = status_ff;
   assign res_hit    = hit_ff;
   assign res_match  = match_ff;
   assign res_insert = ins_ff;
   assign res_count  = count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH)) else $error("entry count above depth");
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_APPEND && !full) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not add an entry");
   a_hit_pos: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> ins_ff == CNT_W'(match_ff)) else $error("hit index mismatch");
`endif
endmodule
`default_nettype wire

/* rtl/emt_ctrl.sv */
// Controller of the extent map table: sequences each request over the datapath.
// Depends on emt_pkg; commands emt_datapath and reads its status.
`default_nettype none
module emt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_action,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire emt_pkg::dp_status_type stat,
   output emt_pkg::dp_cmd_type        cmd
);
   import emt_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           ret_norm_ff, ret_norm_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_norm_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_norm_ff <= ret_norm_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ret_norm_in = ret_norm_ff;
      cmd.op      = OP_NOP;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_START;
               unique case (action_type'(req_action))
                  ACT_APPEND:    state_in = S_APPEND;
                  ACT_REMOVE:    state_in = S_REMOVE;
                  ACT_FIND:      state_in = S_FIND;
                  ACT_NORMALIZE: state_in = S_SORT_I;
               endcase
            end
         end
         S_APPEND: begin
            cmd.op   = OP_APPEND;
            state_in = S_DONE;
         end
         S_REMOVE: begin
            cmd.op = OP_CHECK_IDX;
            if (stat.bad_idx) begin
               state_in = S_DONE;
            end else begin
               ret_norm_in = 1'b0;
               state_in    = S_DEL;
            end
         end
         S_FIND: begin
            if (stat.i_end) begin
               cmd.op   = OP_FIND_MISS;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_READ_I;
               state_in = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            cmd.op   = OP_FIND_CMP;
            state_in = stat.find_stop ? S_DONE : S_FIND;
         end
         S_SORT_I: begin
            if (stat.i_end) begin
               cmd.op   = OP_I_ZERO;
               state_in = S_MERGE;
            end else begin
               cmd.op   = OP_READ_I;
               state_in = S_SORT_LOAD;
            end
         end
         S_SORT_LOAD: begin
            cmd.op   = OP_LOAD_CUR;
            state_in = S_SORT_J;
         end
         S_SORT_J: begin
            if (stat.j_end) begin
               cmd.op   = OP_WRITE_CUR;
               state_in = S_SORT_I;
            end else begin
               cmd.op   = OP_READ_J;
               state_in = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            cmd.op   = OP_SORT_CMP;
            state_in = S_SORT_J;
         end
         S_MERGE: begin
            if (stat.i_end) begin
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_READ_I;
               state_in = S_MERGE_LOAD;
            end
         end
         S_MERGE_LOAD: begin
            cmd.op   = OP_LOAD_CUR;
            state_in = S_MERGE_CHK;
         end
         S_MERGE_CHK: begin
            priority if (stat.zero_len) begin
               cmd.op      = OP_SET_M_I;
               ret_norm_in = 1'b1;
               state_in    = S_DEL;
            end else if (!stat.has_next) begin
               cmd.op   = OP_INC_I;
               state_in = S_MERGE;
            end else begin
               cmd.op   = OP_READ_I1;
               state_in = S_MERGE_CMP;
            end
         end
         S_MERGE_CMP: begin
            if (stat.mergeable) begin
               cmd.op      = OP_MERGE;
               ret_norm_in = 1'b1;
               state_in    = S_DEL;
            end else begin
               cmd.op   = OP_INC_I;
               state_in = S_MERGE;
            end
         end
         S_DEL: begin
            if (stat.m_end) begin
               cmd.op   = OP_DEL_END;
               state_in = ret_norm_ff ? S_MERGE : S_DONE;
            end else begin
               cmd.op   = OP_READ_M1;
               state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            cmd.op   = OP_DEL_WR;
            state_in = S_DEL;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while response pending");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("accepted twice");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
`endif
endmodule
`default_nettype wire

/* rtl/extent_map_table_core.sv */
// Top level of the extent map table: request, response and register channels.
// Depends on emt_pkg, emt_ifs, emt_ctrl and emt_datapath.
//
// One request is taken at a time; req_chan.ready is high only while idle.
// The response waits in registers until rsp_chan.ready; a stalled receiver
// holds the block, and no new request is taken until the response leaves.
// Append writes the new entry at the end of the table; remove checks the
// index and, if it is good, shifts each later entry down; find scans the
// entries in order until one covers the block or starts above it.
// Normalize runs an exchange sort, then a merge walk that deletes entries
// of zero length and merges an entry with the next one when both are
// contiguous, share the unwritten flag and fit within max_merge_length,
// shifting later entries down on each deletion. The entry memory has a
// single read port, whose read data is registered. Reset empties the table
// and loads max_merge_length with 32768; entry contents are undefined until written.
// The register port is always ready and should be written only while idle.
`default_nettype none
module extent_map_table_core (
   input wire logic clock,
   input wire logic reset,
   emt_req_if.sink   req_chan,
   emt_rsp_if.source rsp_chan,
   emt_csr_if.sink   csr_chan
);
   import emt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   assign csr_chan.ready = 1'b1;

   emt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   emt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_lblk   (req_chan.logical_block),
      .req_pstart (req_chan.physical_start),
      .req_len    (req_chan.extent_length),
      .req_flag   (req_chan.unwritten_flag),
      .req_index  (req_chan.entry_index),
      .csr_we     (csr_chan.valid),
      .csr_data   (csr_chan.data),
      .res_status (rsp_chan.status),
      .res_hit    (rsp_chan.hit),
      .res_match  (rsp_chan.match_index),
      .res_insert (rsp_chan.insert_position),
      .res_count  (rsp_chan.entry_count)
   );
endmodule
`default_nettype wire

/* tb/tb_emt_ifs.sv */
// Response record type used by the testbench's predictor and checker.
// Depends on emt_pkg.
`timescale 1ns / 1ps
package tb_emt_types;
   import emt_pkg::*;
   typedef struct packed {
      logic [1:0]       status;
      logic             hit;
      logic [IDX_W-1:0] match_index;
      logic [CNT_W-1:0] insert_position;
      logic [CNT_W-1:0] entry_count;
   } answer_type;
endpackage

/* tb/tb_top.sv */
// Testbench for extent_map_table_core: sends append, remove, find and normalize
// requests, predicts every response with its own table model, and checks each one.
`timescale 1ns / 1ps
module tb_top;
   import emt_pkg::*;
   import tb_emt_types::*;

   logic clock = 0;
   logic reset = 1;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   emt_req_if req_chan();
   emt_rsp_if rsp_chan();
   emt_csr_if csr_chan();

   extent_map_table_core u_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   entry_type  table_model [TABLE_DEPTH];
   int         entries_held;
   logic [15:0] merge_limit;
   answer_type answers_due [$];
   int mismatches, responses_seen, requests_sent, idle_cycles;
   int burst_left, stall_mode;
   bit timed_out;

   function automatic void drop_entry(int k);
      for (int m = k; m + 1 < entries_held; m++) table_model[m] = table_model[m + 1];
      entries_held--;
   endfunction

   function automatic void tidy_table();
      entry_type t;
      longint lc, ln;
      int i;
      for (int a = 0; a < entries_held; a++)
         for (int b = a + 1; b < entries_held; b++)
            if (table_model[a].lstart > table_model[b].lstart) begin
               t = table_model[a]; table_model[a] = table_model[b]; table_model[b] = t;
            end
      i = 0;
      while (i < entries_held) begin
         if (table_model[i].len == 0) begin
            drop_entry(i);
            continue;
         end
         if (i + 1 < entries_held) begin
            lc = table_model[i].len;
            ln = table_model[i + 1].len;
            if (table_model[i].unwritten == table_model[i + 1].unwritten &&
                longint'(table_model[i].lstart) + lc == longint'(table_model[i + 1].lstart) &&
                longint'(table_model[i].pstart) + lc == longint'(table_model[i + 1].pstart) &&
                lc + ln <= longint'(merge_limit)) begin
               table_model[i].len = 16'(lc + ln);
               drop_entry(i + 1);
               continue;
            end
         end
         i++;
      end
   endfunction

   function automatic answer_type predict_answer(action_type act, logic [31:0] lblk,
         logic [31:0] pblk, logic [15:0] len, logic uflag, logic [5:0] idx);
      answer_type r;
      r = '0;
      case (act)
         ACT_APPEND: begin
            if (entries_held >= TABLE_DEPTH) r.status = ST_FULL;
            else begin
               table_model[entries_held] = '{unwritten: uflag, len: len, pstart: pblk,
                                             lstart: lblk};
               entries_held++;
            end
         end
         ACT_REMOVE: begin
            if (idx >= entries_held) r.status = ST_BAD_INDEX;
            else drop_entry(idx);
         end
         ACT_FIND: begin
            r.insert_position = CNT_W'(entries_held);
            for (int k = 0; k < entries_held; k++) begin
               if (lblk < table_model[k].lstart) begin
                  r.insert_position = CNT_W'(k);
                  break;
               end
               if (longint'(lblk) < longint'(table_model[k].lstart) + table_model[k].len) begin
                  r.hit = 1;
                  r.match_index = IDX_W'(k);
                  r.insert_position = CNT_W'(k);
                  break;
               end
            end
         end
         default: tidy_table();
      endcase
      r.entry_count = CNT_W'(entries_held);
      return r;
   endfunction

   task automatic send_request(action_type act, logic [31:0] lblk, logic [31:0] pblk,
         logic [15:0] len, logic uflag, logic [5:0] idx);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req_chan.valid <= 1;
      req_chan.action <= act;
      req_chan.logical_block <= lblk;
      req_chan.physical_start <= pblk;
      req_chan.extent_length <= len;
      req_chan.unwritten_flag <= uflag;
      req_chan.entry_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      answers_due.push_back(predict_answer(act, lblk, pblk, len, uflag, idx));
      requests_sent++;
      req_chan.valid <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (answers_due.size() != 0 && !timed_out) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_merge_limit(logic [15:0] value);
      wait_drained();
      csr_chan.valid <= 1;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 0;
      merge_limit = value;
   endtask

   task automatic append_run(int n, logic [31:0] lbase, logic [31:0] pbase, logic [15:0] len,
         logic uflag);
      for (int k = 0; k < n; k++)
         send_request(ACT_APPEND, lbase + k * len, pbase + k * len, len, uflag, '0);
   endtask

   task automatic test_directed();
      send_request(ACT_FIND, 32'd5, '0, '0, 0, '0);
      send_request(ACT_REMOVE, '0, '0, '0, 0, 6'd0);
      send_request(ACT_NORMALIZE, '0, '0, '0, 0, '0);
      send_request(ACT_APPEND, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF, 1, 6'h3F);
      send_request(ACT_APPEND, 32'd100, 32'd200, 16'd0, 0, '0);
      send_request(ACT_APPEND, 32'd10, 32'd50, 16'd5, 0, '0);
      send_request(ACT_APPEND, 32'd15, 32'd55, 16'd5, 0, '0);
      send_request(ACT_APPEND, 32'd10, 32'd90, 16'd3, 1, '0);
      send_request(ACT_FIND, 32'hFFFF_FFFF, '0, '0, 0, '0);
      send_request(ACT_FIND, 32'd12, '0, '0, 0, '0);
      send_request(ACT_FIND, 32'd0, '0, '0, 0, '0);
      send_request(ACT_REMOVE, '0, '0, '0, 0, 6'd63);
      send_request(ACT_NORMALIZE, '0, '0, '0, 0, '0);
      send_request(ACT_FIND, 32'd17, '0, '0, 0, '0);
      send_request(ACT_REMOVE, '0, '0, '0, 0, 6'd1);
      send_request(ACT_REMOVE, '0, '0, '0, 0, 6'd0);
   endtask

   task automatic test_full_table();
      append_run(TABLE_DEPTH - entries_held + 2, 32'd1000, 32'd5000, 16'd4, 0);
      send_request(ACT_FIND, 32'd1100, '0, '0, 0, '0);
      send_request(ACT_REMOVE, '0, '0, '0, 0, 6'd63);
      send_request(ACT_NORMALIZE, '0, '0, '0, 0, '0);
      while (entries_held > 0) send_request(ACT_REMOVE, '0, '0, '0, 0, 6'd0);
   endtask

   task automatic test_merge_limits(logic [15:0] limit);
      write_merge_limit(limit);
      append_run(6, 32'd7000, 32'd9000, 16'd1, 1);
      append_run(3, 32'd6000, 32'd8000, 16'hFFFF, 0);
      send_request(ACT_NORMALIZE, '0, '0, '0, 0, '0);
      while (entries_held > 0) send_request(ACT_REMOVE, '0, '0, '0, 0, 6'd0);
   endtask

   task automatic test_random(int count);
      int n;
      logic [31:0] lb, pb;
      for (int k = 0; k < count; k++) begin
         n = $urandom_range(0, 99);
         if (n < 35) begin
            if ($urandom_range(0, 1)) begin
               lb = $urandom_range(0, 400);
               pb = lb + $urandom_range(0, 1) * 32'd1000;
            end else begin
               lb = $urandom;
               pb = $urandom;
            end
            send_request(ACT_APPEND, lb, pb, 16'($urandom_range(0, 1) ? $urandom_range(0, 40)
                         : $urandom), 1'($urandom_range(0, 3) == 0), 6'($urandom));
         end else if (n < 55)
            send_request(ACT_REMOVE, $urandom, $urandom, 16'($urandom), 1'($urandom),
                         6'($urandom_range(0, 1) ? $urandom_range(0, entries_held + 1)
                                                 : $urandom));
         else if (n < 92)
            send_request(ACT_FIND, $urandom_range(0, 1) ? 32'($urandom_range(0, 500))
                         : 32'($urandom), $urandom, 16'($urandom), 1'($urandom), 6'($urandom));
         else
            send_request(ACT_NORMALIZE, $urandom, $urandom, 16'($urandom), 1'($urandom),
                         6'($urandom));
         if (entries_held > 24 && $urandom_range(0, 3) == 0)
            while (entries_held > 4) send_request(ACT_REMOVE, '0, '0, '0, 0,
                                                  6'($urandom_range(0, entries_held - 1)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else begin
         stall_mode = (responses_seen / 200) % 3;
         rsp_chan.ready <= (stall_mode == 0) ? 1'b1 :
                           (stall_mode == 1) ? ($urandom_range(0, 3) != 0) :
                           ($urandom_range(0, 1) == 1);
      end
   end

   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.status, rsp_chan.hit, rsp_chan.match_index,
                 rsp_chan.insert_position, rsp_chan.entry_count};
         responses_seen++;
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = answers_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("response %0d mismatch: expected %p got %p",
                                              responses_seen, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 200000) begin
         timed_out = 1;
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 0; req_chan.action = ACT_APPEND; req_chan.logical_block = 0;
      req_chan.physical_start = 0; req_chan.extent_length = 0;
      req_chan.unwritten_flag = 0; req_chan.entry_index = 0;
      csr_chan.valid = 0; csr_chan.data = 0;
      entries_held = 0; merge_limit = MAX_MERGE_RESET;
      mismatches = 0; responses_seen = 0; requests_sent = 0; idle_cycles = 0;
      burst_left = 0; timed_out = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_merge_limits(16'd0);
      test_merge_limits(16'd1);
      test_merge_limits(16'd4);
      test_merge_limits(16'hFFFF);
      write_merge_limit(16'd20);
      test_random(650);
      write_merge_limit(16'(MAX_MERGE_RESET));
      test_random(650);
      wait_drained();
      $display("Covered %0d requests and %0d responses over append, remove, find, normalize,",
               requests_sent, responses_seen);
      $display("a full table and merge limits from zero to the maximum.");
      if (mismatches == 0 && answers_due.size() == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end
endmodule

/* sim.f */
rtl/emt_pkg.sv
rtl/emt_ifs.sv
rtl/emt_datapath.sv
rtl/emt_ctrl.sv
rtl/extent_map_table_core.sv
tb/tb_emt_ifs.sv
tb/tb_top.sv
